// File: design/bclm_pkg.sv
// Package for the block cache tag/LRU manager: field widths, request and
// status codes, and the structs shared by the top level and the scan unit.
// No dependencies.
`default_nettype none

package bclm_pkg;

   localparam int SLOTS_DEFAULT = 256;

   localparam int REQ_W    = 2;
   localparam int DEV_W    = 32;
   localparam int BLK_W    = 64;
   localparam int STAMP_W  = 64;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 2;

   // request codes
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SYNC  = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FETCH_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_DIRTY   = 2'd2;

   typedef struct packed {
      logic [DEV_W-1:0] device;
      logic [BLK_W-1:0] block;
   } tag_type;

   // per-entry control presented to the scan unit
   typedef struct packed {
      logic live;
      logic valid;
      logic dirty;
   } elem_ctrl_type;

   // scan summary flags
   typedef struct packed {
      logic hit_found;
      logic free_found;
      logic best_dirty;
      logic sync_found;
   } scan_flags_type;

endpackage

`default_nettype wire

// File: design/bclm_if.sv
// Channel interfaces for the block cache tag/LRU manager: request and
// response, each with valid/ready and payload. Depends on bclm_pkg.
`default_nettype none

interface bclm_req_if;
   logic                          valid;
   logic                          ready;
   logic [bclm_pkg::REQ_W-1:0]    req_type;
   logic [bclm_pkg::DEV_W-1:0]    device_id;
   logic [bclm_pkg::BLK_W-1:0]    block_addr;
   logic                          fetch_ok;

   modport source (output valid, req_type, device_id, block_addr, fetch_ok,
                   input ready);
   modport sink   (input valid, req_type, device_id, block_addr, fetch_ok,
                   output ready);
endinterface

interface bclm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bclm_pkg::STATUS_W-1:0] status;
   logic                          hit;
   logic [bclm_pkg::SLOT_W-1:0]   slot;
   logic                          writeback_valid;
   logic [bclm_pkg::DEV_W-1:0]    writeback_device;
   logic [bclm_pkg::BLK_W-1:0]    writeback_block;

   modport source (output valid, status, hit, slot, writeback_valid,
                   writeback_device, writeback_block, input ready);
   modport sink   (input valid, status, hit, slot, writeback_valid,
                   writeback_device, writeback_block, output ready);
endinterface

`default_nettype wire

// File: design/bclm_scan.sv
// Scan unit: evaluates one tag entry per cycle and keeps the running lookup,
// free-slot, victim and first-dirty results. Depends on bclm_pkg.
`default_nettype none

module bclm_scan #(
   parameter int  SLOTS = bclm_pkg::SLOTS_DEFAULT,
   localparam int IW    = $clog2(SLOTS)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire bclm_pkg::elem_ctrl_type         elem_ctrl,
   input  wire logic [IW-1:0]                   elem_idx,
   input  wire bclm_pkg::tag_type               elem_tag,
   input  wire logic [bclm_pkg::STAMP_W-1:0]    elem_stamp,
   input  wire bclm_pkg::tag_type               key,
   output bclm_pkg::scan_flags_type             flags,
   output logic [IW-1:0]                        hit_idx,
   output logic [IW-1:0]                        free_idx,
   output logic [IW-1:0]                        best_idx,
   output bclm_pkg::tag_type                    best_tag,
   output logic [IW-1:0]                        sync_idx,
   output bclm_pkg::tag_type                    sync_tag
);

   bclm_pkg::scan_flags_type         flags_ff, flags_in;
   logic [IW-1:0]                    hit_idx_ff, hit_idx_in;
   logic [IW-1:0]                    free_idx_ff, free_idx_in;
   logic [IW-1:0]                    best_idx_ff, best_idx_in;
   bclm_pkg::tag_type                best_tag_ff, best_tag_in;
   logic [bclm_pkg::STAMP_W-1:0]     best_stamp_ff, best_stamp_in;
   logic [IW-1:0]                    sync_idx_ff, sync_idx_in;
   bclm_pkg::tag_type                sync_tag_ff, sync_tag_in;
   logic                             match;
   logic                             better;

   assign match  = elem_ctrl.valid && (elem_tag == key);
   // clean beats dirty, then older stamp; strict so ties keep the lower index
   assign better = (!elem_ctrl.dirty && flags_ff.best_dirty) ||
                   ((elem_ctrl.dirty == flags_ff.best_dirty) &&
                    (elem_stamp < best_stamp_ff));

   always_comb begin
      flags_in      = flags_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_tag_in   = best_tag_ff;
      best_stamp_in = best_stamp_ff;
      sync_idx_in   = sync_idx_ff;
      sync_tag_in   = sync_tag_ff;
      if (start) begin
         flags_in = '0;
      end else if (elem_ctrl.live) begin
         if (!flags_ff.hit_found && match) begin
            flags_in.hit_found = 1'b1;
            hit_idx_in         = elem_idx;
         end
         if (!flags_ff.free_found && !elem_ctrl.valid) begin
            flags_in.free_found = 1'b1;
            free_idx_in         = elem_idx;
         end
         if (!flags_ff.free_found && elem_ctrl.valid &&
             ((elem_idx == '0) || better)) begin
            flags_in.best_dirty = elem_ctrl.dirty;
            best_idx_in         = elem_idx;
            best_tag_in         = elem_tag;
            best_stamp_in       = elem_stamp;
         end
         if (!flags_ff.sync_found && elem_ctrl.valid && elem_ctrl.dirty) begin
            flags_in.sync_found = 1'b1;
            sync_idx_in         = elem_idx;
            sync_tag_in         = elem_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_tag_ff   <= best_tag_in;
      best_stamp_ff <= best_stamp_in;
      sync_idx_ff   <= sync_idx_in;
      sync_tag_ff   <= sync_tag_in;
   end

   assign flags    = flags_ff;
   assign hit_idx  = hit_idx_ff;
   assign free_idx = free_idx_ff;
   assign best_idx = best_idx_ff;
   assign best_tag = best_tag_ff;
   assign sync_idx = sync_idx_ff;
   assign sync_tag = sync_tag_ff;

endmodule

`default_nettype wire

// File: design/block_cache_tag_lru_manager.sv
// Tag store of a fully associative block cache with SLOTS slots (default
// 256). Each request (read, write or sync step) is taken only while the
// block is idle and yields exactly one response. After acceptance the
// tag and stamp memories are read one entry per cycle, each entry is
// evaluated in the cycle after its read, and every entry passes through a
// single compare unit, which resolves the lookup, the victim choice (first
// free slot, else clean before dirty, then oldest stamp, then lowest index)
// and the first dirty slot for a sync step in one pass.
// The decision state then updates the stores and loads the response. The
// block is ready again in the cycle after the decision, so a new request
// is never accepted before the previous one has been decided.
// The response register frees the request side: a new request may be
// accepted while the previous response still waits; the decision state
// holds until that response is taken. Valid and dirty bits live in
// flip-flops cleared by reset; tags and stamps of free slots are never
// consulted, so the memories need no clearing pass after reset. Depends
// on bclm_pkg, bclm_if, bclm_scan.
`default_nettype none

module block_cache_tag_lru_manager #(
   parameter int SLOTS = bclm_pkg::SLOTS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bclm_req_if.sink    req_bus,
   bclm_rsp_if.source  rsp_bus
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = IW + 1;

   // sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   // ---------------------------------------------------------------------
   // State and request registers
   // ---------------------------------------------------------------------
   logic [1:0]                          state_ff, state_in;
   logic [CW-1:0]                       cnt_ff, cnt_in;
   logic                                eval_live_ff, eval_live_in;
   logic [IW-1:0]                       eval_idx_ff, eval_idx_in;
   logic [bclm_pkg::REQ_W-1:0]          req_type_ff, req_type_in;
   bclm_pkg::tag_type                   req_tag_ff, req_tag_in;
   logic                                req_fetch_ff, req_fetch_in;
   logic [bclm_pkg::STAMP_W-1:0]        use_clock_ff, use_clock_in;
   logic [SLOTS-1:0]                    valid_ff, valid_in;
   logic [SLOTS-1:0]                    dirty_ff, dirty_in;

   // response register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [bclm_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                                rsp_hit_ff, rsp_hit_in;
   logic [bclm_pkg::SLOT_W-1:0]         rsp_slot_ff, rsp_slot_in;
   logic                                rsp_wbv_ff, rsp_wbv_in;
   bclm_pkg::tag_type                   rsp_wb_ff, rsp_wb_in;

   // tag and stamp memories, registered read port
   bclm_pkg::tag_type                   tag_mem [SLOTS];
   logic [bclm_pkg::STAMP_W-1:0]        stamp_mem [SLOTS];
   bclm_pkg::tag_type                   rd_tag_ff;
   logic [bclm_pkg::STAMP_W-1:0]        rd_stamp_ff;
   logic                                rd_valid_ff;
   logic                                rd_dirty_ff;

   // handshake and sequencing
   logic                                req_accept;
   logic                                rd_en;
   logic [IW-1:0]                       rd_addr;
   logic                                decide_go;

   // scan unit results
   bclm_pkg::elem_ctrl_type             elem_ctrl;
   bclm_pkg::scan_flags_type            flags;
   logic [IW-1:0]                       hit_idx, free_idx, best_idx, sync_idx;
   bclm_pkg::tag_type                   best_tag, sync_tag;

   // decision outputs
   logic [bclm_pkg::STATUS_W-1:0]       o_status;
   logic                                o_hit;
   logic [IW-1:0]                       o_idx;
   logic [IW+bclm_pkg::SLOT_W-1:0]      o_idx_ext;
   logic                                o_wbv;
   bclm_pkg::tag_type                   o_wb;
   logic [IW-1:0]                       wr_idx;
   logic                                tag_we;
   logic                                stamp_we;
   logic                                set_valid;
   logic                                dirty_we;
   logic                                dirty_val;

   assign req_accept = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);

   // response register must be free (or draining) before we commit
   assign decide_go = (state_ff == ST_DECIDE) && (!rsp_valid_ff || rsp_bus.ready);

   // issue one memory read per scan cycle until every slot is out
   assign rd_en   = (state_ff == ST_SCAN) && (cnt_ff < CW'(SLOTS));
   assign rd_addr = cnt_ff[IW-1:0];

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      eval_live_in = 1'b0;
      eval_idx_in  = eval_idx_ff;
      req_type_in  = req_type_ff;
      req_tag_in   = req_tag_ff;
      req_fetch_in = req_fetch_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               req_type_in         = req_bus.req_type;
               req_tag_in.device   = req_bus.device_id;
               req_tag_in.block    = req_bus.block_addr;
               req_fetch_in        = req_bus.fetch_ok;
               cnt_in              = '0;
               // unknown request type skips the scan; decide emits zeros
               if (req_bus.req_type == bclm_pkg::REQ_READ ||
                   req_bus.req_type == bclm_pkg::REQ_WRITE ||
                   req_bus.req_type == bclm_pkg::REQ_SYNC) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               cnt_in       = cnt_ff + CW'(1);
               eval_live_in = 1'b1;
               eval_idx_in  = rd_addr;
            end
            // last entry is evaluated this cycle
            if (eval_live_ff && (eval_idx_ff == IW'(SLOTS - 1))) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (decide_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Shared compare unit
   // ---------------------------------------------------------------------
   assign elem_ctrl.live  = eval_live_ff;
   assign elem_ctrl.valid = rd_valid_ff;
   assign elem_ctrl.dirty = rd_dirty_ff;

   bclm_scan #(
      .SLOTS (SLOTS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .start      (req_accept),
      .elem_ctrl  (elem_ctrl),
      .elem_idx   (eval_idx_ff),
      .elem_tag   (rd_tag_ff),
      .elem_stamp (rd_stamp_ff),
      .key        (req_tag_ff),
      .flags      (flags),
      .hit_idx    (hit_idx),
      .free_idx   (free_idx),
      .best_idx   (best_idx),
      .best_tag   (best_tag),
      .sync_idx   (sync_idx),
      .sync_tag   (sync_tag)
   );

   // ---------------------------------------------------------------------
   // Decision: result fields and store updates
   // ---------------------------------------------------------------------
   always_comb begin
      o_status  = bclm_pkg::STATUS_OK;
      o_hit     = 1'b0;
      o_idx     = '0;
      o_wbv     = 1'b0;
      o_wb      = '0;
      wr_idx    = '0;
      tag_we    = 1'b0;
      stamp_we  = 1'b0;
      set_valid = 1'b0;
      dirty_we  = 1'b0;
      dirty_val = 1'b0;
      case (req_type_ff)
         bclm_pkg::REQ_READ,
         bclm_pkg::REQ_WRITE: begin
            if (flags.hit_found) begin
               o_hit     = 1'b1;
               wr_idx    = hit_idx;
               o_idx     = hit_idx;
               stamp_we  = 1'b1;
               dirty_we  = (req_type_ff == bclm_pkg::REQ_WRITE);
               dirty_val = 1'b1;
            end else if ((req_type_ff == bclm_pkg::REQ_READ) && !req_fetch_ff) begin
               // failed fetch: nothing changes
               o_status = bclm_pkg::STATUS_FETCH_FAIL;
            end else begin
               wr_idx    = flags.free_found ? free_idx : best_idx;
               o_idx     = wr_idx;
               tag_we    = 1'b1;
               stamp_we  = 1'b1;
               set_valid = 1'b1;
               dirty_we  = 1'b1;
               dirty_val = (req_type_ff == bclm_pkg::REQ_WRITE);
               if (!flags.free_found && flags.best_dirty) begin
                  o_wbv = 1'b1;
                  o_wb  = best_tag;
               end
            end
         end
         bclm_pkg::REQ_SYNC: begin
            if (flags.sync_found) begin
               wr_idx    = sync_idx;
               o_idx     = sync_idx;
               dirty_we  = 1'b1;
               dirty_val = 1'b0;
               o_wbv     = 1'b1;
               o_wb      = sync_tag;
            end else begin
               o_status = bclm_pkg::STATUS_NO_DIRTY;
            end
         end
         default: begin
            // unknown request: all-zero response
         end
      endcase
   end

   // low 8 bits of the slot index, zero-extended for small caches
   assign o_idx_ext = {{bclm_pkg::SLOT_W{1'b0}}, o_idx};

   always_comb begin
      use_clock_in  = use_clock_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_wbv_in    = rsp_wbv_ff;
      rsp_wb_in     = rsp_wb_ff;
      if (decide_go) begin
         if (stamp_we) begin
            use_clock_in = use_clock_ff + bclm_pkg::STAMP_W'(1);
         end
         if (set_valid) begin
            valid_in[wr_idx] = 1'b1;
         end
         if (dirty_we) begin
            dirty_in[wr_idx] = dirty_val;
         end
         rsp_valid_in  = 1'b1;
         rsp_status_in = o_status;
         rsp_hit_in    = o_hit;
         rsp_slot_in   = o_idx_ext[bclm_pkg::SLOT_W-1:0];
         rsp_wbv_in    = o_wbv;
         rsp_wb_in     = o_wb;
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         eval_live_ff <= 1'b0;
         use_clock_ff <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         eval_live_ff <= eval_live_in;
         use_clock_ff <= use_clock_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      eval_idx_ff   <= eval_idx_in;
      req_type_ff   <= req_type_in;
      req_tag_ff    <= req_tag_in;
      req_fetch_ff  <= req_fetch_in;
      rsp_status_ff <= rsp_status_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_wbv_ff    <= rsp_wbv_in;
      rsp_wb_ff     <= rsp_wb_in;
   end

   // memories: writes only in the decision cycle, reads only while scanning
   always_ff @(posedge clock) begin
      if (decide_go && tag_we) begin
         tag_mem[wr_idx] <= req_tag_ff;
      end
      if (decide_go && stamp_we) begin
         stamp_mem[wr_idx] <= use_clock_in;
      end
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         rd_dirty_ff <= dirty_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Response channel
   // ---------------------------------------------------------------------
   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.status           = rsp_status_ff;
   assign rsp_bus.hit              = rsp_hit_ff;
   assign rsp_bus.slot             = rsp_slot_ff;
   assign rsp_bus.writeback_valid  = rsp_wbv_ff;
   assign rsp_bus.writeback_device = rsp_wb_ff.device;
   assign rsp_bus.writeback_block  = rsp_wb_ff.block;

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
// Self-checking testbench for block_cache_tag_lru_manager: directed table, then
// random read/write/sync traffic against a tag-store predictor with LRU victims.
// Depends on bclm_pkg, bclm_if and the block's RTL.
`timescale 1ns / 100ps

module testbench;
   import bclm_pkg::*;

   localparam int SLOTS          = SLOTS_DEFAULT;
   localparam int POOL           = SLOTS + SLOTS / 4;   // more tags than slots -> evictions
   localparam int RANDOM_ITEMS   = 1000;
   localparam int DIRECTED_COUNT = 21;
   localparam int WATCHDOG_LIMIT = 8 * (SLOTS + 16);
   localparam int REPORT_LIMIT   = 10;

   // request code the block must treat as a no-op
   localparam logic [REQ_W-1:0] REQ_UNDEFINED = 2'd3;

   typedef struct {
      logic [REQ_W-1:0] kind;
      logic [DEV_W-1:0] device;
      logic [BLK_W-1:0] block;
      logic             fetch_ok;
   } cache_req_t;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic                wb_valid;
      logic [DEV_W-1:0]    wb_device;
      logic [BLK_W-1:0]    wb_block;
   } cache_rsp_t;

   // given = 1: the response below is the expectation, else the predictor's
   typedef struct {
      cache_req_t rq;
      bit         given;
      cache_rsp_t rsp;
   } directed_row_t;

   logic clock;
   logic reset;

   bclm_req_if req_bus ();
   bclm_rsp_if rsp_bus ();

   block_cache_tag_lru_manager #(.SLOTS(SLOTS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // ---------------------------------------------------------------------
   // Tag store mirror. 2-state types so everything starts at zero, as the
   // block does after reset.
   // ---------------------------------------------------------------------
   bit               tag_valid  [SLOTS];
   bit               tag_dirty  [SLOTS];
   bit [DEV_W-1:0]   tag_device [SLOTS];
   bit [BLK_W-1:0]   tag_block  [SLOTS];
   bit [STAMP_W-1:0] tag_stamp  [SLOTS];
   bit [STAMP_W-1:0] stamp_clock;

   cache_rsp_t pending_outcomes[$];   // expected responses, oldest first

   // run statistics
   int requests_sent;
   int responses_checked;
   int mismatches;
   int hit_count;
   int writeback_count;
   int fetch_fail_count;
   int empty_sync_count;

   // shared "calm" flag: when set neither side inserts idle cycles
   bit calm;
   int rsp_stall;
   int idle_cycles;

   cache_rsp_t got;
   cache_rsp_t want;

   logic [DEV_W-1:0] pool_device [POOL];
   logic [BLK_W-1:0] pool_block  [POOL];
   logic [DEV_W-1:0] device_set  [4];

   directed_row_t directed_rows [DIRECTED_COUNT];

   function automatic int draw_wait();
      return calm ? 0 : $urandom_range(0, 3);
   endfunction

   // Applies one request to the mirror and returns the response it yields.
   function automatic cache_rsp_t resolve_request(cache_req_t rq);
      cache_rsp_t r;
      int         s;
      int         i;
      bit         found;
      bit         free;
      r = '{default: '0};
      s = 0;
      found = 1'b0;
      free = 1'b0;
      if (rq.kind == REQ_READ || rq.kind == REQ_WRITE) begin
         for (i = 0; i < SLOTS; i++) begin
            if (!found && tag_valid[i] && tag_device[i] == rq.device &&
                tag_block[i] == rq.block) begin
               found = 1'b1;
               s = i;
            end
         end
         if (found) begin
            r.hit = 1'b1;
         end else if (rq.kind == REQ_READ && !rq.fetch_ok) begin
            // failed fetch: no state touched, everything else zero
            r.status = STATUS_FETCH_FAIL;
            return r;
         end else begin
            // victim: first free slot; else clean over dirty, oldest stamp,
            // lowest index on ties
            for (i = 0; i < SLOTS; i++) begin
               if (!free) begin
                  if (!tag_valid[i]) begin
                     s = i;
                     free = 1'b1;
                  end else if (i != 0 &&
                               ((!tag_dirty[i] && tag_dirty[s]) ||
                                (tag_dirty[i] == tag_dirty[s] &&
                                 tag_stamp[i] < tag_stamp[s]))) begin
                     s = i;
                  end
               end
            end
            if (tag_valid[s] && tag_dirty[s]) begin
               r.wb_valid  = 1'b1;
               r.wb_device = tag_device[s];
               r.wb_block  = tag_block[s];
            end
            tag_valid[s]  = 1'b1;
            tag_dirty[s]  = 1'b0;
            tag_device[s] = rq.device;
            tag_block[s]  = rq.block;
         end
         if (rq.kind == REQ_WRITE)
            tag_dirty[s] = 1'b1;
         stamp_clock = stamp_clock + 1'b1;
         tag_stamp[s] = stamp_clock;
         r.slot = s[SLOT_W-1:0];
      end else if (rq.kind == REQ_SYNC) begin
         for (i = 0; i < SLOTS; i++) begin
            if (!found && tag_valid[i] && tag_dirty[i]) begin
               found = 1'b1;
               s = i;
            end
         end
         if (found) begin
            tag_dirty[s] = 1'b0;
            r.slot      = s[SLOT_W-1:0];
            r.wb_valid  = 1'b1;
            r.wb_device = tag_device[s];
            r.wb_block  = tag_block[s];
         end else begin
            r.status = STATUS_NO_DIRTY;
         end
      end
      // undefined request code: no state change, all-zero response
      return r;
   endfunction

   // Drives one request after a random gap and records its expectation at
   // the accepting edge. valid is only lowered when a gap follows.
   task automatic issue_request(input cache_req_t rq, input bit given,
                                input cache_rsp_t given_rsp);
      int         gap;
      cache_rsp_t predicted;
      gap = draw_wait();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= rq.kind;
      req_bus.device_id  <= rq.device;
      req_bus.block_addr <= rq.block;
      req_bus.fetch_ok   <= rq.fetch_ok;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = resolve_request(rq);
      if (given)
         predicted = given_rsp;
      pending_outcomes.push_back(predicted);
      requests_sent++;
      hit_count        += predicted.hit;
      writeback_count  += predicted.wb_valid;
      fetch_fail_count += (predicted.status == STATUS_FETCH_FAIL);
      empty_sync_count += (predicted.status == STATUS_NO_DIRTY);
   endtask

   // Holds the request side until every outstanding response has come back.
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, counted only while valid is up
   // so the stall really lands on a waiting response.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = 0;
         rsp_bus.ready <= 1'b0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         got.status    = rsp_bus.status;
         got.hit       = rsp_bus.hit;
         got.slot      = rsp_bus.slot;
         got.wb_valid  = rsp_bus.writeback_valid;
         got.wb_device = rsp_bus.writeback_device;
         got.wb_block  = rsp_bus.writeback_block;
         if (pending_outcomes.size() == 0) begin
            if (mismatches < REPORT_LIMIT)
               $display("unexpected response: status %0d hit %0d slot %0d",
                        got.status, got.hit, got.slot);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            responses_checked++;
            if (got.status !== want.status || got.hit !== want.hit ||
                got.slot !== want.slot || got.wb_valid !== want.wb_valid ||
                got.wb_device !== want.wb_device || got.wb_block !== want.wb_block)
            begin
               if (mismatches < REPORT_LIMIT) begin
                  $display("mismatch on response %0d:", responses_checked);
                  $display("  expected status %0d hit %0d slot %0d wb %0d dev %h blk %h",
                           want.status, want.hit, want.slot, want.wb_valid,
                           want.wb_device, want.wb_block);
                  $display("  actual   status %0d hit %0d slot %0d wb %0d dev %h blk %h",
                           got.status, got.hit, got.slot, got.wb_valid,
                           got.wb_device, got.wb_block);
               end
               mismatches++;
            end
         end
         rsp_stall = draw_wait();
         rsp_bus.ready <= (rsp_stall == 0);
      end else if (rsp_bus.valid && rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= (rsp_stall == 0);
      end else if (rsp_stall == 0) begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: cycles without any handshake on either channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d responses outstanding",
                     idle_cycles, pending_outcomes.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      cache_req_t rq;
      cache_rsp_t none_rsp;
      int         n;
      int         pick;
      int         idx;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_READ;
      req_bus.device_id  = '0;
      req_bus.block_addr = '0;
      req_bus.fetch_ok   = 1'b0;
      rsp_bus.ready      = 1'b0;
      calm               = 1'b0;
      none_rsp           = '{default: '0};

      // Directed rows. Typed expectations follow straight from an empty
      // store: slot 0 then slot 1 get filled, syncs walk dirty slots in
      // index order, failed fetch returns only its status, the undefined code zeros.
      directed_rows = '{
         // sync on an empty store
         '{'{REQ_SYNC, '0, '0, 1'b0}, 1'b1, '{STATUS_NO_DIRTY, 1'b0, 8'd0, 1'b0, '0, '0}},
         // read miss, fetch failed
         '{'{REQ_READ, '1, '1, 1'b0}, 1'b1, '{STATUS_FETCH_FAIL, 1'b0, 8'd0, 1'b0, '0, '0}},
         // read miss, fill slot 0 with all-ones tags
         '{'{REQ_READ, '1, '1, 1'b1}, 1'b1, '{STATUS_OK, 1'b0, 8'd0, 1'b0, '0, '0}},
         // write miss with fetch_ok low (ignored), fills slot 1
         '{'{REQ_WRITE, '0, '0, 1'b0}, 1'b1, '{STATUS_OK, 1'b0, 8'd1, 1'b0, '0, '0}},
         // read hit with fetch_ok low
         '{'{REQ_READ, '1, '1, 1'b0}, 1'b1, '{STATUS_OK, 1'b1, 8'd0, 1'b0, '0, '0}},
         // write hit dirties slot 0
         '{'{REQ_WRITE, '1, '1, 1'b1}, 1'b1, '{STATUS_OK, 1'b1, 8'd0, 1'b0, '0, '0}},
         // undefined request code
         '{'{REQ_UNDEFINED, '1, '1, 1'b1}, 1'b1, '{STATUS_OK, 1'b0, 8'd0, 1'b0, '0, '0}},
         // syncs clean slot 0, then slot 1 (zero tags), then nothing left
         '{'{REQ_SYNC, '1, '1, 1'b1}, 1'b1, '{STATUS_OK, 1'b0, 8'd0, 1'b1, '1, '1}},
         '{'{REQ_SYNC, '0, '0, 1'b0}, 1'b1, '{STATUS_OK, 1'b0, 8'd1, 1'b1, '0, '0}},
         '{'{REQ_SYNC, '0, '0, 1'b1}, 1'b1, '{STATUS_NO_DIRTY, 1'b0, 8'd0, 1'b0, '0, '0}},
         // same device, other block; same block, other device
         '{'{REQ_READ, '1, '0, 1'b1}, 1'b0, none_rsp},
         '{'{REQ_READ, '0, '1, 1'b1}, 1'b0, none_rsp},
         '{'{REQ_WRITE, 32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0}, 1'b0, none_rsp},
         '{'{REQ_WRITE, 32'h0000_0001, 64'h0000_0000_0000_0001, 1'b1}, 1'b0, none_rsp},
         '{'{REQ_READ, 32'h8000_0000, 64'h8000_0000_0000_0000, 1'b0}, 1'b0, none_rsp},
         '{'{REQ_READ, 32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0}, 1'b0, none_rsp},
         '{'{REQ_WRITE, 32'hAAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1}, 1'b0, none_rsp},
         '{'{REQ_UNDEFINED, '0, '0, 1'b0}, 1'b1, '{STATUS_OK, 1'b0, 8'd0, 1'b0, '0, '0}},
         '{'{REQ_SYNC, '0, '0, 1'b0}, 1'b0, none_rsp},
         '{'{REQ_SYNC, '1, '1, 1'b1}, 1'b0, none_rsp},
         // write hit on a slot that an earlier sync cleaned
         '{'{REQ_WRITE, '0, '0, 1'b1}, 1'b0, none_rsp}
      };

      // Tag pool: few devices so device compares matter, every eighth entry
      // reuses the previous block address under a possibly different device.
      for (n = 0; n < 4; n++)
         device_set[n] = $urandom;
      for (n = 0; n < POOL; n++) begin
         pool_device[n] = device_set[$urandom_range(0, 3)];
         if (n % 8 == 7)
            pool_block[n] = pool_block[n-1];
         else
            pool_block[n] = {$urandom, $urandom};
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < DIRECTED_COUNT; n++)
         issue_request(directed_rows[n].rq, directed_rows[n].given,
                       directed_rows[n].rsp);
      drain_responses();

      // Random traffic over the pool; a small share uses fresh random tags
      // so every address bit toggles.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2)
            drain_responses();
         if ($urandom_range(0, 49) == 0)
            calm = !calm;
         pick = $urandom_range(0, 99);
         idx  = $urandom_range(0, POOL - 1);
         rq.device   = pool_device[idx];
         rq.block    = pool_block[idx];
         rq.fetch_ok = ($urandom_range(0, 99) < 85);
         if (pick < 42) begin
            rq.kind = REQ_READ;
         end else if (pick < 77) begin
            rq.kind = REQ_WRITE;
         end else if (pick < 91) begin
            rq.kind = REQ_SYNC;
         end else if (pick < 93) begin
            rq.kind = REQ_UNDEFINED;
         end else begin
            rq.kind   = (pick % 2 == 0) ? REQ_READ : REQ_WRITE;
            rq.device = $urandom;
            rq.block  = {$urandom, $urandom};
         end
         issue_request(rq, 1'b0, none_rsp);
      end

      req_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      // catch any stray response after the last one
      repeat (SLOTS + 8) @(posedge clock);

      $display("%0d requests (%0d from the table), %0d responses checked, %0d mismatches",
               requests_sent, DIRECTED_COUNT, responses_checked, mismatches);
      $display("%0d hits, %0d write-backs, %0d failed fetches, %0d syncs with nothing dirty",
               hit_count, writeback_count, fetch_fail_count, empty_sync_count);
      if (mismatches == 0 && pending_outcomes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
